// File: hw/rtl/bspd_pkg.sv
// Shared types and constants for the byte stream pixel decoder.
`default_nettype none
package bspd_pkg;

  localparam int unsigned CfgIndexWidth = 1;
  localparam int unsigned CfgDataWidth  = 2;

  // Configuration register indexes
  localparam logic [CfgIndexWidth-1:0] CFG_PIXEL_FORMAT = 1'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_GRAY_ONLY    = 1'd1;

  // 16-bit fixed-point conversion coefficients
  localparam int signed KCrR = 91881;
  localparam int signed KCbG = 21889;
  localparam int signed KCrG = 46792;
  localparam int signed KCbB = 116129;
  localparam int unsigned ChromaOffset = 128;

  // floor(x / 3) == (x * DivThreeMul) >> DivThreeShift for x < 2048
  localparam int unsigned DivThreeMul   = 683;
  localparam int unsigned DivThreeShift = 11;

  typedef enum logic [1:0] {
    FMT_MONO = 2'd0,
    FMT_RGB  = 2'd1,
    FMT_YCC  = 2'd2
  } fmt_t;

  typedef enum logic [2:0] {
    GRP_MONO,
    GRP_RGB,
    GRP_RGB_GRAY,
    GRP_YCC,
    GRP_YCC_GRAY
  } grp_kind_t;

  // A completed byte group, ready for conversion
  typedef struct packed {
    grp_kind_t  kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } group_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_run;
  } pixel_t;

  // One or two pixels made from one group
  typedef struct packed {
    pixel_t first;
    pixel_t second;
    logic   two;
  } pair_t;

endpackage
`default_nettype wire

// File: hw/rtl/bspd_if.sv
// Valid/ready channel interfaces for the raw byte stream and the pixel stream.
`default_nettype none
interface byte_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       frame_start;

  modport source(output valid, stream_byte, frame_start, input ready);
  modport sink(input valid, stream_byte, frame_start, output ready);
endinterface

interface pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_of_run;

  modport source(output valid, red, green, blue, last_of_run, input ready);
  modport sink(input valid, red, green, blue, last_of_run, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bspd_assembler.sv
// Byte phase tracking and group assembly; registers each completed group.
`default_nettype none
module bspd_assembler (
  input  wire logic            clk,
  input  wire logic            rst,
  byte_stream_if.sink          stream,
  input  wire bspd_pkg::fmt_t  pixel_format,
  input  wire logic            gray_only,
  output bspd_pkg::group_t     grp,
  output logic                 grp_valid,
  input  wire logic            grp_ready
);
  import bspd_pkg::*;

  logic [1:0] byte_phase;
  logic [1:0] byte_phase_next;
  logic [7:0] held [3];
  logic [7:0] held_next [3];
  logic [1:0] phase;
  logic       complete;
  logic       accept;
  group_t     grp_next;

  assign stream.ready = !grp_valid || grp_ready;
  assign accept       = stream.valid && stream.ready;

  always_comb begin
    phase           = stream.frame_start ? 2'd0 : byte_phase;
    byte_phase_next = 2'd0;
    held_next       = held;
    complete        = 1'b1;
    grp_next.kind   = GRP_MONO;
    grp_next.b0     = stream.stream_byte;
    grp_next.b1     = held[1];
    grp_next.b2     = held[2];
    grp_next.b3     = stream.stream_byte;
    unique case (pixel_format)
      FMT_RGB: begin
        if (phase < 2'd2) begin
          held_next[phase] = stream.stream_byte;
          byte_phase_next  = phase + 2'd1;
          complete         = 1'b0;
        end
        // any later phase, stale ones included, completes from the held bytes and the current byte
        grp_next.kind = gray_only ? GRP_RGB_GRAY : GRP_RGB;
        grp_next.b0   = held[0];
        grp_next.b1   = held[1];
        grp_next.b2   = stream.stream_byte;
      end
      FMT_YCC: begin
        if (phase < 2'd3) begin
          held_next[phase] = stream.stream_byte;
          byte_phase_next  = phase + 2'd1;
          complete         = 1'b0;
        end
        grp_next.kind = gray_only ? GRP_YCC_GRAY : GRP_YCC;
        grp_next.b0   = held[0];
        grp_next.b1   = held[1];
        grp_next.b2   = held[2];
      end
      default: begin
        // monochrome, and the unused code decodes the same way
        grp_next.kind = GRP_MONO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase <= 2'd0;
      held[0]    <= 8'd0;
      held[1]    <= 8'd0;
      held[2]    <= 8'd0;
      grp_valid  <= 1'b0;
    end else begin
      if (accept) begin
        byte_phase <= byte_phase_next;
        held       <= held_next;
      end
      if (accept && complete) begin
        grp_valid <= 1'b1;
      end else if (grp_ready) begin
        grp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && complete) begin
      grp <= grp_next;
    end
  end

  a_phase_clears: assert property (@(posedge clk) disable iff (rst)
    accept && complete |=> byte_phase == 2'd0)
    else $error("byte phase not cleared after a completed group");

  a_group_held: assert property (@(posedge clk) disable iff (rst)
    grp_valid && !grp_ready |=> grp_valid && $stable(grp))
    else $error("stalled group changed");

  a_partial_no_group: assert property (@(posedge clk) disable iff (rst)
    accept && !complete && !grp_valid |=> !grp_valid)
    else $error("group raised for an incomplete byte group");

endmodule
`default_nettype wire

// File: hw/rtl/bspd_convert.sv
// Group to pixel conversion: gray, RGB pass-through, RGB average, YCbCr to RGB.
`default_nettype none
module bspd_convert (
  input  wire bspd_pkg::group_t grp,
  output bspd_pkg::pair_t       pair
);
  import bspd_pkg::*;

  logic signed [8:0]  cb;
  logic signed [8:0]  cr;
  logic signed [31:0] prod_cr_r;
  logic signed [31:0] prod_cb_g;
  logic signed [31:0] prod_cr_g;
  logic signed [31:0] prod_cb_b;
  logic signed [10:0] term_r;
  logic signed [10:0] term_g;
  logic signed [10:0] term_b;
  logic [9:0]         rgb_sum;
  logic [19:0]        avg_prod;
  logic [7:0]         gray_avg;
  pixel_t             ycc0;
  pixel_t             ycc1;

  function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  function automatic pixel_t ycc_pixel(input logic [7:0] y, input logic last);
    logic signed [10:0] ys;
    pixel_t p;
    ys            = signed'({3'b000, y});
    p.red         = clamp_byte(ys + term_r);
    p.green       = clamp_byte(ys - term_g);
    p.blue        = clamp_byte(ys + term_b);
    p.last_of_run = last;
    return p;
  endfunction

  function automatic pixel_t gray_pixel(input logic [7:0] v, input logic last);
    pixel_t p;
    p.red         = v;
    p.green       = v;
    p.blue        = v;
    p.last_of_run = last;
    return p;
  endfunction

  // chroma terms are shared by both pixels of a YCbCr pair
  assign cb = signed'({1'b0, grp.b0}) - 9'sd128;
  assign cr = signed'({1'b0, grp.b2}) - 9'sd128;

  assign prod_cr_r = 32'(cr) * KCrR;
  assign prod_cb_g = 32'(cb) * KCbG;
  assign prod_cr_g = 32'(cr) * KCrG;
  assign prod_cb_b = 32'(cb) * KCbB;

  // arithmetic shift gives the floor on negative products
  assign term_r = 11'(prod_cr_r >>> 16);
  assign term_g = 11'(prod_cb_g >>> 16) + 11'(prod_cr_g >>> 16);
  assign term_b = 11'(prod_cb_b >>> 16);

  assign rgb_sum  = 10'(grp.b0) + 10'(grp.b1) + 10'(grp.b2);
  assign avg_prod = 20'(rgb_sum) * 20'(DivThreeMul);
  assign gray_avg = 8'(avg_prod >> DivThreeShift);

  // the chroma terms are read inside ycc_pixel, so they must be in the sensitivity
  always_comb begin
    ycc0 = ycc_pixel(grp.b1, 1'b0);
    ycc1 = ycc_pixel(grp.b3, 1'b1);
  end

  always_comb begin
    pair.first  = gray_pixel(grp.b0, 1'b1);
    pair.second = gray_pixel(grp.b3, 1'b1);
    pair.two    = 1'b0;
    unique case (grp.kind)
      GRP_MONO: begin
        pair.first = gray_pixel(grp.b0, 1'b1);
      end
      GRP_RGB: begin
        pair.first.red         = grp.b0;
        pair.first.green       = grp.b1;
        pair.first.blue        = grp.b2;
        pair.first.last_of_run = 1'b1;
      end
      GRP_RGB_GRAY: begin
        pair.first = gray_pixel(gray_avg, 1'b1);
      end
      GRP_YCC: begin
        pair.first  = ycc0;
        pair.second = ycc1;
        pair.two    = 1'b1;
      end
      GRP_YCC_GRAY: begin
        pair.first  = gray_pixel(grp.b1, 1'b0);
        pair.second = gray_pixel(grp.b3, 1'b1);
        pair.two    = 1'b1;
      end
      default: begin
        pair.two = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/bspd_pixel_buffer.sv
// Result register holding up to two pixels, drained one pixel per cycle while the sink is ready.
`default_nettype none
module bspd_pixel_buffer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bspd_pkg::pair_t pair,
  input  wire logic            pair_valid,
  output logic                 can_load,
  pixel_if.source              pixels
);
  import bspd_pkg::*;

  logic [1:0] pend;
  pixel_t     head;
  pixel_t     tail;
  logic       pop;
  logic       load;

  assign pixels.valid       = pend != 2'd0;
  assign pixels.red         = head.red;
  assign pixels.green       = head.green;
  assign pixels.blue        = head.blue;
  assign pixels.last_of_run = head.last_of_run;

  assign pop      = pixels.valid && pixels.ready;
  assign can_load = (pend == 2'd0) || (pend == 2'd1 && pop);
  assign load     = pair_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 2'd0;
    end else if (load) begin
      pend <= pair.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      pend <= pend - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      head <= pair.first;
      tail <= pair.second;
    end else if (pop) begin
      head <= tail;
    end
  end

  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    pend != 2'd3)
    else $error("pixel buffer count out of range");

  a_pair_first_not_last: assert property (@(posedge clk) disable iff (rst)
    pend == 2'd2 |-> !head.last_of_run)
    else $error("first pixel of a pair flagged last");

  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    pend == 2'd1 |-> head.last_of_run)
    else $error("final pending pixel not flagged last");

endmodule
`default_nettype wire

// File: hw/rtl/byte_stream_pixel_decoder.sv
// Top level: raw camera byte stream in, RGB888 pixels out.
// A completed group is registered, then loaded into the pixel register as its first pixel.
// One byte per cycle unless stalled; a YCbCr pair holds the pixel reg until both pixels go.
// The byte side stalls only under output backpressure, once group and pixel regs are full.
// Reset (rst, synchronous): format monochrome, gray off, byte phase and held bytes zero.
// Pixel register and group register are emptied by reset; payloads are not cleared.
`default_nettype none
module byte_stream_pixel_decoder (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [bspd_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  wire logic [bspd_pkg::CfgDataWidth-1:0]   cfg_data,
  byte_stream_if.sink                              stream,
  pixel_if.source                                  pixels
);
  import bspd_pkg::*;

  // configuration registers; the user must write them only while idle (not enforced)
  fmt_t   pixel_format;
  logic   gray_only;

  // assembled group between the byte side and the conversion logic
  group_t grp;
  logic   grp_valid;
  logic   grp_ready;
  pair_t  pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_MONO;
      gray_only    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIXEL_FORMAT: pixel_format <= fmt_t'(cfg_data[1:0]);
        CFG_GRAY_ONLY:    gray_only    <= cfg_data[0];
        default:          gray_only    <= gray_only;
      endcase
    end
  end

  // byte phase, held bytes; registers each group that completes
  bspd_assembler u_assembler (
    .clk          (clk),
    .rst          (rst),
    .stream       (stream),
    .pixel_format (pixel_format),
    .gray_only    (gray_only),
    .grp          (grp),
    .grp_valid    (grp_valid),
    .grp_ready    (grp_ready)
  );

  // constant multiplies and clamps, one group per cycle unless the group register stalls
  bspd_convert u_convert (
    .grp  (grp),
    .pair (pair)
  );

  // result register; takes a new group while empty or as its last pixel leaves
  bspd_pixel_buffer u_buffer (
    .clk        (clk),
    .rst        (rst),
    .pair       (pair),
    .pair_valid (grp_valid),
    .can_load   (grp_ready),
    .pixels     (pixels)
  );

endmodule
`default_nettype wire
